/* sv/sss_pkg.sv */
// Shared types and constants for the sample set statistics block.
// Depends on nothing; every other file in this folder imports it.
package sss_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int SMP_W       = 16;
	localparam int CNT_W       = 13;
	localparam int MASK_W      = 6;
	localparam int COST_W      = 44;
	localparam int SABS_W      = 28;
	localparam int SSUM_W      = 29;
	localparam int SSQ_W       = 43;
	localparam int SDE_W       = 46;

	// Shared divider and square root sizes.
	localparam int DVD_W       = 88;
	localparam int DVS_W       = 25;
	localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
	localparam int RAD_W       = 64;
	localparam int ROOT_W      = 32;
	localparam int SQRT_CNT_W  = $clog2(ROOT_W + 1);

	// Objective mask bit positions.
	localparam int OBJ_MAX  = 0;
	localparam int OBJ_SUM  = 1;
	localparam int OBJ_MEAN = 2;
	localparam int OBJ_RMS  = 3;
	localparam int OBJ_STD  = 4;
	localparam int OBJ_TMP  = 5;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	// Accumulators of one finished set, handed from front to back.
	typedef struct packed {
		logic [CNT_W-1:0]         cnt;
		logic [SMP_W-1:0]         max_abs;
		logic [SABS_W-1:0]        sum_abs;
		logic signed [SSUM_W-1:0] ssum;
		logic [SSQ_W-1:0]         ssq;
		logic [SDE_W-1:0]         sde;
		logic [MASK_W-1:0]        mask;
	} snap_t;

	// One result item.
	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              empty_mask;
	} res_t;

endpackage

/* sv/sss_front.sv */
// Front part: holds the objective mask and accumulates one sample per cycle while the queue is not full.
// Depends on sss_pkg; hands each finished set to the queue as an snap_t.
module sss_front import sss_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [SMP_W-1:0] sample,
	input  logic                    last,
	input  logic                    push,
	output logic                    full,
	input  logic                    cfg_we,
	input  logic [MASK_W-1:0]       cfg_data,
	input  logic                    q_full,
	output logic                    snap_push,
	output snap_t                   snap
);

	logic [MASK_W-1:0]        mask_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [SMP_W-1:0]         max_q;
	logic [SABS_W-1:0]        sabs_q;
	logic signed [SSUM_W-1:0] ssum_q;
	logic [SSQ_W-1:0]         ssq_q;
	logic [SDE_W-1:0]         sde_q;
	logic signed [SMP_W-1:0]  prev_q;
	logic signed [SMP_W-1:0]  older_q;

	logic                     accept;
	logic                     acc_en;
	logic signed [SMP_W-1:0]  neg_smp;
	logic [SMP_W-1:0]         mag;
	logic signed [17:0]       dm;
	logic signed [17:0]       dm_neg;
	logic [16:0]              dm_abs;
	logic [31:0]              sq_mag;
	logic [33:0]              sq_dm;
	snap_t                    cur;
	snap_t                    nxt;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign acc_en = cnt_q < CNT_W'(MAX_SAMPLES);

	// Magnitude and second difference of the incoming sample.
	assign neg_smp = -sample;
	assign mag     = sample[SMP_W-1] ? neg_smp : sample;
	assign dm      = {{2{older_q[SMP_W-1]}}, older_q} + {{2{sample[SMP_W-1]}}, sample}
	                 - {prev_q[SMP_W-1], prev_q, 1'b0};
	assign dm_neg  = -dm;
	assign dm_abs  = dm[17] ? dm_neg[16:0] : dm[16:0];
	assign sq_mag  = mag * mag;
	assign sq_dm   = dm_abs * dm_abs;

	// Current and updated accumulators.
	always_comb begin
		cur.cnt     = cnt_q;
		cur.max_abs = max_q;
		cur.sum_abs = sabs_q;
		cur.ssum    = ssum_q;
		cur.ssq     = ssq_q;
		cur.sde     = sde_q;
		cur.mask    = mask_q;
		nxt         = cur;
		nxt.cnt     = cnt_q + CNT_W'(1);
		nxt.max_abs = (mag > max_q) ? mag : max_q;
		nxt.sum_abs = sabs_q + SABS_W'(mag);
		nxt.ssum    = ssum_q + SSUM_W'(sample);
		nxt.ssq     = ssq_q + SSQ_W'(sq_mag);
		nxt.sde     = (cnt_q >= CNT_W'(2)) ? sde_q + SDE_W'(sq_dm) : sde_q;
	end

	assign snap      = acc_en ? nxt : cur;
	assign snap_push = accept && last;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_W'(1);
		end else if (cfg_we) begin
			mask_q <= cfg_data;
		end
	end

	// Accumulator update; a set end clears everything for the next set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			max_q   <= '0;
			sabs_q  <= '0;
			ssum_q  <= '0;
			ssq_q   <= '0;
			sde_q   <= '0;
			prev_q  <= '0;
			older_q <= '0;
		end else if (accept) begin
			if (last) begin
				cnt_q   <= '0;
				max_q   <= '0;
				sabs_q  <= '0;
				ssum_q  <= '0;
				ssq_q   <= '0;
				sde_q   <= '0;
				prev_q  <= '0;
				older_q <= '0;
			end else if (acc_en) begin
				cnt_q   <= nxt.cnt;
				max_q   <= nxt.max_abs;
				sabs_q  <= nxt.sum_abs;
				ssum_q  <= nxt.ssum;
				ssq_q   <= nxt.ssq;
				sde_q   <= nxt.sde;
				prev_q  <= sample;
				older_q <= prev_q;
			end
		end
	end

endmodule

/* sv/sss_queue.sv */
// Two-entry queue of finished sets between the front and the back.
// Depends on sss_pkg for snap_t.
module sss_queue import sss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  snap_t din,
	input  logic  pop,
	output snap_t dout,
	output logic  full,
	output logic  empty
);

	snap_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = ent_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

/* sv/sss_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on sss_pkg for its widths.
module sss_div import sss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVS_W:0]       rem_sh;
	logic [DVS_W:0]       diff;
	logic                 ge;

	assign rem_sh   = {rem_q, quo_q[DVD_W-1]};
	assign diff     = rem_sh - {1'b0, dvs_q};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	// One shift and trial subtraction per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
			cnt_q  <= DIV_CNT_W'(DVD_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			quo_q  <= {quo_q[DVD_W-2:0], ge};
			rem_q  <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			cnt_q  <= cnt_q - DIV_CNT_W'(1);
			busy_q <= cnt_q != DIV_CNT_W'(1);
			done_q <= cnt_q == DIV_CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

/* sv/sss_sqrt.sv */
// Floor square root, one result bit per cycle.
// Depends on sss_pkg for its widths.
module sss_sqrt import sss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              busy,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]      x_q;
	logic [ROOT_W+1:0]     rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [ROOT_W+1:0]     rem_sh;
	logic [ROOT_W+1:0]     trial;
	logic                  ge;

	assign rem_sh = {rem_q[ROOT_W-1:0], x_q[RAD_W-1:RAD_W-2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign busy   = busy_q;
	assign done   = done_q;
	assign root   = root_q;

	// Two radicand bits enter per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= SQRT_CNT_W'(ROOT_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			x_q    <= {x_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
			cnt_q  <= cnt_q - SQRT_CNT_W'(1);
			busy_q <= cnt_q != SQRT_CNT_W'(1);
			done_q <= cnt_q == SQRT_CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

/* sv/sss_back.sv */
// Back part: turns one finished set into a cost through a sequencer that
// shares one multiplier, sss_div and sss_sqrt. Depends on sss_pkg.
module sss_back import sss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  snap_t             head,
	input  logic              q_empty,
	output logic              q_pop,
	output logic [COST_W-1:0] cost,
	output logic              empty_mask,
	output logic              empty,
	input  logic              pop
);

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_MEAN = 13'b0000000000010,
		ST_RMS  = 13'b0000000000100,
		ST_RSQ  = 13'b0000000001000,
		ST_MLO  = 13'b0000000010000,
		ST_MHI  = 13'b0000000100000,
		ST_MSQ  = 13'b0000001000000,
		ST_MNN  = 13'b0000010000000,
		ST_SDIV = 13'b0000100000000,
		ST_SSQ  = 13'b0001000000000,
		ST_TMP  = 13'b0010000000000,
		ST_AVG  = 13'b0100000000000,
		ST_WR   = 13'b1000000000000
	} state_t;

	state_t            state_q;
	snap_t             job_q;
	logic [63:0]       total_q;
	logic [55:0]       prod_q;
	logic [DVS_W-1:0]  nn_q;
	logic [2:0]        sel_q;
	logic              op_q;
	res_t              res_q;
	res_t              out_q;
	logic              out_valid_q;

	logic [2:0]        sel_head;
	logic [63:0]       base_head;
	logic [27:0]       mul_a;
	logic [27:0]       mul_b;
	logic [55:0]       mul_p;
	logic [SSUM_W-1:0] ssum_neg;
	logic [27:0]       ssum_abs;
	logic              tmp_en;
	logic              div_start;
	logic [DVD_W-1:0]  div_dvd;
	logic [DVS_W-1:0]  div_dvs;
	logic              div_busy;
	logic              div_done;
	logic [DVD_W-1:0]  div_quo;
	logic              sqrt_start;
	logic              sqrt_busy;
	logic              sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;

	// Number of selected objectives and the terms that need no division.
	always_comb begin
		sel_head = 3'd0;
		for (int i = 0; i < MASK_W; i++) begin
			sel_head = sel_head + {2'b00, head.mask[i]};
		end
		base_head = (head.mask[OBJ_MAX] ? {32'd0, head.max_abs, 16'd0} : 64'd0)
		          + (head.mask[OBJ_SUM] ? {20'd0, head.sum_abs, 16'd0} : 64'd0);
	end

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign ssum_neg = -job_q.ssum;
	assign ssum_abs = job_q.ssum[SSUM_W-1] ? ssum_neg[27:0] : job_q.ssum[27:0];
	assign tmp_en   = job_q.mask[OBJ_TMP] && (job_q.cnt >= CNT_W'(3));

	// Shared multiplier operands for the variance terms.
	always_comb begin
		mul_a = 28'(job_q.cnt);
		mul_b = 28'(job_q.cnt);
		unique case (state_q)
			ST_MLO: mul_b = 28'(job_q.ssq[20:0]);
			ST_MHI: mul_b = 28'(job_q.ssq[SSQ_W-1:21]);
			ST_MSQ: begin
				mul_a = ssum_abs;
				mul_b = ssum_abs;
			end
			default: mul_b = 28'(job_q.cnt);
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Divider operands by step.
	always_comb begin
		div_dvd = '0;
		div_dvs = DVS_W'(1);
		unique case (state_q)
			ST_MEAN: begin
				div_dvd = DVD_W'({job_q.sum_abs, 16'd0});
				div_dvs = DVS_W'(job_q.cnt);
			end
			ST_RMS: begin
				div_dvd = DVD_W'({job_q.ssq, 32'd0});
				div_dvs = DVS_W'(job_q.cnt);
			end
			ST_SDIV: begin
				div_dvd = DVD_W'({prod_q[54:0], 32'd0});
				div_dvs = nn_q;
			end
			ST_TMP: begin
				div_dvd = DVD_W'({job_q.sde, 14'd0});
				div_dvs = DVS_W'(job_q.cnt - CNT_W'(2));
			end
			ST_AVG: begin
				div_dvd = DVD_W'(total_q);
				div_dvs = DVS_W'(sel_q);
			end
			default: div_dvs = DVS_W'(1);
		endcase
	end

	assign div_start = !op_q && (((state_q == ST_MEAN) && job_q.mask[OBJ_MEAN])
	                   || ((state_q == ST_RMS) && job_q.mask[OBJ_RMS])
	                   || (state_q == ST_SDIV)
	                   || ((state_q == ST_TMP) && tmp_en)
	                   || (state_q == ST_AVG));
	assign sqrt_start = !op_q && ((state_q == ST_RSQ) || (state_q == ST_SSQ));

	sss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	sss_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quo[RAD_W-1:0]),
		.busy     (sqrt_busy),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// Sequencer over the selected metrics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= '0;
			total_q <= '0;
			prod_q  <= '0;
			nn_q    <= '0;
			sel_q   <= '0;
			op_q    <= 1'b0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						job_q <= head;
						sel_q <= sel_head;
						if (sel_head == 3'd0) begin
							res_q   <= '{cost: '0, empty_mask: 1'b1};
							state_q <= ST_WR;
						end else if (head.cnt == '0) begin
							res_q   <= '{cost: '0, empty_mask: 1'b0};
							state_q <= ST_WR;
						end else begin
							total_q <= base_head;
							state_q <= ST_MEAN;
						end
					end
				end
				ST_MEAN: begin
					if (!job_q.mask[OBJ_MEAN]) begin
						state_q <= ST_RMS;
					end else if (!op_q) begin
						op_q <= 1'b1;
					end else if (div_done) begin
						op_q    <= 1'b0;
						total_q <= total_q + div_quo[63:0];
						state_q <= ST_RMS;
					end
				end
				ST_RMS: begin
					if (!job_q.mask[OBJ_RMS]) begin
						state_q <= ST_MLO;
					end else if (!op_q) begin
						op_q <= 1'b1;
					end else if (div_done) begin
						op_q    <= 1'b0;
						state_q <= ST_RSQ;
					end
				end
				ST_RSQ: begin
					if (!op_q) begin
						op_q <= 1'b1;
					end else if (sqrt_done) begin
						op_q    <= 1'b0;
						total_q <= total_q + 64'(sqrt_root);
						state_q <= ST_MLO;
					end
				end
				ST_MLO: begin
					if (!job_q.mask[OBJ_STD]) begin
						state_q <= ST_TMP;
					end else begin
						prod_q  <= mul_p;
						state_q <= ST_MHI;
					end
				end
				ST_MHI: begin
					prod_q  <= prod_q + {mul_p[34:0], 21'd0};
					state_q <= ST_MSQ;
				end
				ST_MSQ: begin
					// n times the sum of squares less the squared sum.
					prod_q  <= prod_q - mul_p;
					state_q <= ST_MNN;
				end
				ST_MNN: begin
					nn_q    <= mul_p[DVS_W-1:0];
					state_q <= ST_SDIV;
				end
				ST_SDIV: begin
					if (!op_q) begin
						op_q <= 1'b1;
					end else if (div_done) begin
						op_q    <= 1'b0;
						state_q <= ST_SSQ;
					end
				end
				ST_SSQ: begin
					if (!op_q) begin
						op_q <= 1'b1;
					end else if (sqrt_done) begin
						op_q    <= 1'b0;
						total_q <= total_q + 64'(sqrt_root);
						state_q <= ST_TMP;
					end
				end
				ST_TMP: begin
					if (!tmp_en) begin
						state_q <= ST_AVG;
					end else if (!op_q) begin
						op_q <= 1'b1;
					end else if (div_done) begin
						op_q    <= 1'b0;
						total_q <= total_q + div_quo[63:0];
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (!op_q) begin
						op_q <= 1'b1;
					end else if (div_done) begin
						op_q           <= 1'b0;
						res_q.cost     <= (|div_quo[DVD_W-1:COST_W]) ? COST_MAX
						                  : div_quo[COST_W-1:0];
						res_q.empty_mask <= 1'b0;
						state_q        <= ST_WR;
					end
				end
				ST_WR: begin
					if (!out_valid_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register; a waiting result holds until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if ((state_q == ST_WR) && !out_valid_q) begin
			out_valid_q <= 1'b1;
			out_q       <= res_q;
		end else if (pop && out_valid_q) begin
			out_valid_q <= 1'b0;
		end
	end

	assign cost       = out_q.cost;
	assign empty_mask = out_q.empty_mask;
	assign empty      = !out_valid_q;

`ifndef SYNTHESIS
	a_div_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_sqrt_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !sqrt_busy)
		else $error("square root started while busy");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WR) && !out_valid_q) |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("finished result not loaded into output register");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(out_q)))
		else $error("waiting result lost or changed before its transfer");
`endif

endmodule

/* sv/sample_set_statistics.sv */
// Top level of the sample set statistics block: front accumulator, set queue
// and back finalizer. Depends on sss_pkg, sss_front, sss_queue and sss_back.
//
//   channel   handshake          payload
//   input     push / full        sample[15:0] signed, last
//   result    pop / empty        cost[43:0], empty_mask
//   config    objective_mask_we  objective_mask[5:0]
//
// The front takes one sample per cycle while full is low; full rises only
// while two finished sets wait for the back. The back runs the bit-serial
// divider once for each selected divided metric and once for the final
// average, and the square root after the RMS and deviation divisions. A set
// with an empty mask or no samples skips both.
// Reset clears all accumulators and sets objective_mask to 1.
// A result waiting on the output stops the front only once the queue fills.
module sample_set_statistics import sss_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [SMP_W-1:0] sample,
	input  logic                    last,
	input  logic                    push,
	output logic                    full,
	output logic [COST_W-1:0]       cost,
	output logic                    empty_mask,
	output logic                    empty,
	input  logic                    pop,
	input  logic                    objective_mask_we,
	input  logic [MASK_W-1:0]       objective_mask
);

	snap_t snap_in;
	snap_t snap_out;
	logic  snap_push;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;

	sss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.last      (last),
		.push      (push),
		.full      (full),
		.cfg_we    (objective_mask_we),
		.cfg_data  (objective_mask),
		.q_full    (q_full),
		.snap_push (snap_push),
		.snap      (snap_in)
	);

	sss_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (snap_push),
		.din    (snap_in),
		.pop    (q_pop),
		.dout   (snap_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	sss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (snap_out),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.cost       (cost),
		.empty_mask (empty_mask),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
